[design/pfc_pkg.sv]
// pfc_pkg: shared types and constants for the pixel format converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

   localparam int unsigned BPP_W = 6;
   localparam logic [BPP_W-1:0] BPP_RESET = 6'd16;
   localparam logic [BPP_W-1:0] BPP_MONO = 6'd1;
   localparam logic [BPP_W-1:0] BPP_GREY_LIMIT = 6'd8;
   localparam logic [BPP_W-1:0] BPP_332 = 6'd8;
   localparam logic [BPP_W-1:0] BPP_444 = 6'd12;
   localparam logic [BPP_W-1:0] BPP_555 = 6'd15;
   localparam logic [BPP_W-1:0] BPP_565 = 6'd16;

   localparam logic [9:0] SUM_MID = 10'd382;
   localparam logic [9:0] SUM_FULL = 10'd765;
   // floor(x / 765) ~ (x * RECIP) >> RECIP_SHIFT, low by at most one
   localparam logic [14:0] RECIP = 15'd21931;
   localparam int unsigned RECIP_SHIFT = 24;

   typedef enum logic [1:0] {
      K_DIRECT = 2'd0,
      K_UNPREM = 2'd1,
      K_GREY_HW = 2'd2,
      K_GREY_GEN = 2'd3
   } kind_type;

   typedef struct packed {
      logic [6:0] rem;
      logic [6:0] dvs;
      logic [7:0] lo;
      logic [7:0] quo;
      logic sat;
   } lane_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] hdr;
      logic [31:0] direct;
      logic [16:0] x;
      logic [7:0] q0;
      logic [10:0] xrem;
      lane_type [2:0] lanes;
   } stage_type;

   function automatic lane_type div_step(lane_type l);
      lane_type n;
      logic [7:0] t;
      n = l;
      t = {l.rem, l.lo[7]};
      if (t >= {1'b0, l.dvs}) begin
         n.rem = 7'(t - {1'b0, l.dvs});
         n.quo = {l.quo[6:0], 1'b1};
      end else begin
         n.rem = t[6:0];
         n.quo = {l.quo[6:0], 1'b0};
      end
      n.lo = {l.lo[6:0], 1'b0};
      return n;
   endfunction

endpackage

`default_nettype wire

[design/pixel_format_converter_core.sv]
// pixel_format_converter_core: converts colours between 24-bit RGB and the
// hardware pixel format, with alpha premultiply and un-premultiply.
// Depends on pfc_pkg.
//
// Usage:
//   req_*  : input beats (req_type, req_color_in), valid/stall handshake.
//   rsp_*  : result beats (rsp_color_out), valid/stall handshake.
//   csr_*  : write of bits_per_pixel; write only while the block is idle.
// Pipeline: four register stages; a beat accepted at the input moves through
// p1_ff, p2_ff, p3_ff and p4_ff, and rsp_valid is high while it sits in p4_ff.
// Throughput: one beat per cycle while rsp_stall is low. Four register stages,
// each carrying two restoring-division steps for the three channel lanes; the
// grey paths use the same lanes or a reciprocal multiply over stages two to four.
// Reset (synchronous, active high) empties the pipeline and sets
// bits_per_pixel to 16.
// When rsp_stall is high the last stage holds its beat; earlier stages
// keep moving into empty slots and req_stall rises only when all four
// stages are full.
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_converter_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [pfc_pkg::BPP_W-1:0] csr_wr_data,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_type,
   input wire logic [31:0] req_color_in,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [31:0] rsp_color_out
);
   import pfc_pkg::*;

   logic [BPP_W-1:0] bpp_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   stage_type p1_ff, p2_ff, p3_ff, p4_ff;
   stage_type p1_in, p2_in, p3_in, p4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   logic [7:0] r, g, b;
   logic [6:0] a;
   logic flag;
   logic [9:0] sum;
   logic [7:0] top8;
   logic [6:0] top;
   logic [6:0] v;
   logic [14:0] gdiv;
   logic [14:0] pr, pg, pb;
   logic [31:0] y;
   logic [17:0] t765;
   logic [7:0] grey_hw;

   assign r = req_color_in[23:16];
   assign g = req_color_in[15:8];
   assign b = req_color_in[7:0];
   assign a = req_color_in[30:24];
   assign flag = req_color_in[31];
   assign sum = {2'b0, r} + {2'b0, g} + {2'b0, b};
   assign top8 = (8'd1 << bpp_ff[2:0]) - 8'd1;
   assign top = top8[6:0];
   assign v = req_color_in[6:0] & top;
   assign gdiv = {v, 8'b0} - {8'b0, v};
   assign pr = r * a;
   assign pg = g * a;
   assign pb = b * a;

   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall = !rdy1;
   assign rsp_valid = v4_ff;
   assign rsp_color_out = p4_ff.direct;

   // stage 1: decode, direct formats, lane setup and two division steps
   always_comb begin
      lane_type ln;
      logic [7:0] ch;
      p1_in = '0;
      p1_in.hdr = req_color_in[31:24];
      p1_in.x = 17'(sum * top);
      p1_in.kind = K_DIRECT;
      p1_in.direct = req_color_in;
      for (int i = 0; i < 3; i++) begin
         ch = (i == 0) ? r : ((i == 1) ? g : b);
         ln = '0;
         if (flag) begin
            ln.rem = ch[7:1];
            ln.lo = {ch[0], 7'b0};
            ln.dvs = a;
            ln.sat = (ch >= {a, 1'b0});
         end else begin
            ln.rem = gdiv[14:8];
            ln.lo = gdiv[7:0];
            ln.dvs = top;
         end
         p1_in.lanes[i] = div_step(div_step(ln));
      end
      if (!req_type) begin
         priority if (flag) begin
            p1_in.direct = {req_color_in[31:24], pr[14:7], pg[14:7], pb[14:7]};
         end else if (bpp_ff == BPP_MONO) begin
            p1_in.direct = {31'b0, sum >= SUM_MID};
         end else if (bpp_ff < BPP_GREY_LIMIT) begin
            p1_in.kind = K_GREY_HW;
         end else if (bpp_ff == BPP_332) begin
            p1_in.direct = {24'b0, r[7:6], g[7:5], b[7:5]};
         end else if (bpp_ff == BPP_565) begin
            p1_in.direct = {16'b0, r[7:3], g[7:2], b[7:3]};
         end else if (bpp_ff == BPP_555) begin
            p1_in.direct = {17'b0, r[7:3], g[7:3], b[7:3]};
         end else if (bpp_ff == BPP_444) begin
            p1_in.direct = {20'b0, r[7:4], g[7:4], b[7:4]};
         end else begin
            p1_in.direct = req_color_in;
         end
      end else begin
         priority if (flag) begin
            p1_in.kind = K_UNPREM;
         end else if (bpp_ff == BPP_MONO) begin
            p1_in.direct = (req_color_in != 32'd0) ? 32'h00FF_FFFF : 32'd0;
         end else if (bpp_ff == 6'd0) begin
            p1_in.direct = 32'd0;
         end else if (bpp_ff < BPP_GREY_LIMIT) begin
            p1_in.kind = K_GREY_GEN;
         end else if (bpp_ff == BPP_332) begin
            p1_in.direct = {8'b0,
               {2{req_color_in[7:6], req_color_in[7:6]}},
               req_color_in[5:3], req_color_in[5:3], req_color_in[5:4],
               req_color_in[2:0], req_color_in[2:0], req_color_in[2:1]};
         end else if (bpp_ff == BPP_565) begin
            p1_in.direct = {8'b0,
               req_color_in[15:11], req_color_in[15:13],
               req_color_in[10:5], req_color_in[10:9],
               req_color_in[4:0], req_color_in[4:2]};
         end else if (bpp_ff == BPP_555) begin
            p1_in.direct = {8'b0, req_color_in[14:10], 3'b0,
               req_color_in[9:5], 3'b0, req_color_in[4:0], 3'b0};
         end else if (bpp_ff == BPP_444) begin
            p1_in.direct = {8'b0, req_color_in[11:8], 4'b0,
               req_color_in[7:4], 4'b0, req_color_in[3:0], 4'b0};
         end else begin
            p1_in.direct = req_color_in;
         end
      end
   end

   // stage 2: reciprocal multiply and two division steps
   assign y = p1_ff.x * RECIP;
   always_comb begin
      p2_in = p1_ff;
      p2_in.q0 = y[RECIP_SHIFT +: 8];
      for (int i = 0; i < 3; i++) begin
         p2_in.lanes[i] = div_step(div_step(p1_ff.lanes[i]));
      end
   end

   // stage 3: remainder of the estimate and two division steps
   assign t765 = p2_ff.q0 * SUM_FULL;
   always_comb begin
      p3_in = p2_ff;
      p3_in.xrem = 11'({1'b0, p2_ff.x} - t765);
      for (int i = 0; i < 3; i++) begin
         p3_in.lanes[i] = div_step(div_step(p2_ff.lanes[i]));
      end
   end

   // stage 4: last steps and result select
   assign grey_hw = p3_ff.q0 + {7'b0, p3_ff.xrem >= {1'b0, SUM_FULL}};
   always_comb begin
      lane_type [2:0] fl;
      logic [7:0] qs [3];
      p4_in = p3_ff;
      for (int i = 0; i < 3; i++) begin
         fl[i] = div_step(div_step(p3_ff.lanes[i]));
         qs[i] = fl[i].sat ? 8'hFF : fl[i].quo;
      end
      unique case (p3_ff.kind)
         K_DIRECT: p4_in.direct = p3_ff.direct;
         K_UNPREM: p4_in.direct = {p3_ff.hdr, qs[0], qs[1], qs[2]};
         K_GREY_HW: p4_in.direct = {24'b0, grey_hw};
         K_GREY_GEN: p4_in.direct = {8'b0, fl[0].quo, fl[0].quo, fl[0].quo};
         default: p4_in.direct = p3_ff.direct;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= BPP_RESET;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bpp_ff <= csr_wr_data;
         end
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_ff <= p1_in;
      end
      if (rdy2) begin
         p2_ff <= p2_in;
      end
      if (rdy3) begin
         p3_ff <= p3_in;
      end
      if (rdy4) begin
         p4_ff <= p4_in;
      end
   end

`ifndef SYNTH
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v1_ff)
      else $error("accepted beat not in stage 1");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff)
      else $error("input stalled with an empty stage");
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      v2_ff && !rdy2 |=> v2_ff && $stable(p2_ff))
      else $error("stage 2 beat lost under stall");
   a_grey_rem: assert property (@(posedge clock) disable iff (reset)
      v3_ff && p3_ff.kind == K_GREY_HW |-> p3_ff.xrem < 11'd1530)
      else $error("reciprocal estimate off by more than one");
`endif

endmodule

`default_nettype wire

[tb/tb_pixel_format_converter_core.sv]
// tb_pixel_format_converter_core: self-checking bench for the pixel format converter.
// Drives random and corner colours at a set of depths, checks each result beat in order.
// Depends on pfc_pkg and pixel_format_converter_core.
`timescale 1ns / 1ps

module tb_pixel_format_converter_core;
   import pfc_pkg::*;

   localparam int unsigned QUIET_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES = 12;

   typedef enum logic {
      TO_HW = 1'b0,
      TO_GEN = 1'b1
   } dir_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [BPP_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = 1'b0;
   logic [31:0] req_color_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_color_out;

   logic [BPP_W-1:0] depth;
   logic [31:0] pending_colors[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_cycles = 0;
   int unsigned quiet = 0;
   bit failed = 1'b0;

   pixel_format_converter_core uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_color_in(req_color_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_color_out(rsp_color_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] unpremultiply(logic [7:0] ch, logic [6:0] a);
      logic [14:0] q;
      if (a == 0) return 8'hFF;
      q = {ch, 7'd0} / a;
      return (q > 255) ? 8'hFF : q[7:0];
   endfunction

   function automatic logic [31:0] convert_color(dir_type dir, logic [31:0] c,
                                                 logic [BPP_W-1:0] bpp);
      logic [7:0] r, g, b, rr, gg, bb;
      logic [6:0] a;
      logic [9:0] sum;
      logic [31:0] top, v, grey;
      r = c[23:16];
      g = c[15:8];
      b = c[7:0];
      a = c[30:24];
      sum = r + g + b;
      if (c[31]) begin
         if (dir == TO_HW) begin
            rr = 8'((16'(r) * a) >> 7);
            gg = 8'((16'(g) * a) >> 7);
            bb = 8'((16'(b) * a) >> 7);
         end else begin
            rr = unpremultiply(r, a);
            gg = unpremultiply(g, a);
            bb = unpremultiply(b, a);
         end
         return {1'b1, a, rr, gg, bb};
      end
      if (dir == TO_HW) begin
         if (bpp == BPP_MONO) return (sum >= SUM_MID) ? 32'd1 : 32'd0;
         if (bpp < BPP_GREY_LIMIT) begin
            top = (32'd1 << bpp) - 1;
            return (sum * top) / SUM_FULL;
         end
         if (bpp == BPP_332) return {24'd0, r[7:6], g[7:5], b[7:5]};
         if (bpp == BPP_565) return {16'd0, r[7:3], g[7:2], b[7:3]};
         if (bpp == BPP_555) return {17'd0, r[7:3], g[7:3], b[7:3]};
         if (bpp == BPP_444) return {20'd0, r[7:4], g[7:4], b[7:4]};
         return c;
      end
      if (bpp == BPP_MONO) return (c != 0) ? 32'hFFFFFF : 32'd0;
      if (bpp < BPP_GREY_LIMIT) begin
         if (bpp == 0) return 32'd0;
         top = (32'd1 << bpp) - 1;
         v = c & top;
         grey = v * 255 / top;
         return {8'd0, grey[7:0], grey[7:0], grey[7:0]};
      end
      if (bpp == BPP_332) begin
         rr = {c[7:6], c[7:6], c[7:6], c[7:6]};
         gg = {c[5:3], c[5:3], c[5:4]};
         bb = {c[2:0], c[2:0], c[2:1]};
         return {8'd0, rr, gg, bb};
      end
      if (bpp == BPP_565)
         return {8'd0, c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
      if (bpp == BPP_555)
         return {8'd0, c[14:10], 3'd0, c[9:5], 3'd0, c[4:0], 3'd0};
      if (bpp == BPP_444)
         return {8'd0, c[11:8], 4'd0, c[7:4], 4'd0, c[3:0], 4'd0};
      return c;
   endfunction

   // receiver: random stall, long hold-off on request; checks on accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            $error("unexpected beat: color_out actual %h", rsp_color_out);
            failed = 1'b1;
         end else begin
            logic [31:0] want;
            want = pending_colors.pop_front();
            if (rsp_color_out !== want) begin
               $error("color_out expected %h actual %h", want, rsp_color_out);
               failed = 1'b1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_color(dir_type dir, logic [31:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= dir;
      req_color_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_colors.push_back(convert_color(dir, c, depth));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_depth(logic [BPP_W-1:0] bpp);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= bpp;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      depth = bpp;
   endtask

   function automatic logic [31:0] random_color();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(5))
         0: c[31:24] = 8'h00;
         1: c[31:24] = {1'b1, 7'(($urandom_range(1) != 0) ? 0 : 127)};
         2: c[23:0] = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h0;
         3: c[31:16] = 16'h0000;
         default: ;
      endcase
      return c;
   endfunction

   task automatic test_corners();
      logic [BPP_W-1:0] corner_depths[6] = '{6'd16, 6'd1, 6'd0, 6'd8, 6'd63, 6'd7};
      foreach (corner_depths[i]) begin
         set_depth(corner_depths[i]);
         send_color(TO_HW, 32'h00000000);
         send_color(TO_HW, 32'h00FFFFFF);
         send_color(TO_HW, 32'h007F7F80);
         send_color(TO_GEN, 32'h7FFFFFFF);
         send_color(TO_GEN, 32'h00000000);
         if (i < 2) begin
            send_color(TO_HW, 32'hFFFFFFFF);
            send_color(TO_GEN, 32'h80FFFFFF);
            send_color(TO_GEN, 32'h81010203);
            send_color(TO_GEN, 32'hFF7F8001);
         end
      end
   endtask

   task automatic test_random(int unsigned count);
      logic [BPP_W-1:0] depth_pool[11] =
         '{6'd1, 6'd2, 6'd5, 6'd7, 6'd8, 6'd12, 6'd15, 6'd16, 6'd24, 6'd0, 6'd63};
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 40 == 0) set_depth(depth_pool[$urandom_range(10)]);
         send_color(dir_type'($urandom_range(1)), random_color());
      end
   endtask

   task automatic test_backpressure();
      set_depth(BPP_565);
      hold_cycles = 60;
      for (int unsigned n = 0; n < 20; n++) send_color(dir_type'($urandom_range(1)), $urandom);
   endtask

   initial begin
      depth = BPP_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_corners();
      send_idle_pct = 17;
      recv_idle_pct = 54;
      test_random(220);
      send_idle_pct = 54;
      recv_idle_pct = 17;
      test_random(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(180);
      wait_idle();
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
